// ----- sv/ggx_specular_brdf_assert.svh -----
// Assertion macros shared by the GGX specular pipeline.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef GGX_SPECULAR_BRDF_ASSERT_SVH
`define GGX_SPECULAR_BRDF_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define GGXB_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// The condition holds in the cycle after the trigger.
`define GGXB_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- sv/ggxb_pkg.sv -----
// Package for the GGX specular pipeline: widths, constants, types and helpers.
// Used by every module of the block; depends on nothing.
package ggxb_pkg;

  localparam int IN_FRAC_BITS  = 15;
  localparam int OUT_FRAC_BITS = 16;
  localparam int IN_W          = 16;
  localparam int WF            = 30;
  localparam int Q_W           = WF + 1;
  localparam int LAM_W         = 32;
  localparam int X_W           = 32;
  localparam int DEN_W         = 34;
  localparam int OUT_W         = 32;
  localparam int NUM_SH        = WF + 1 - OUT_FRAC_BITS;
  localparam int NUM_W         = 2 * Q_W - NUM_SH;

  // Stage counts.
  localparam int FRONT_N  = 4;
  localparam int SQ_N     = Q_W;
  localparam int SQ_REM_W = Q_W + 4;
  localparam int SQ_X_W   = 2 * Q_W;
  localparam int DIV_N    = OUT_W;
  localparam int DIV_LAT  = DIV_N + 1;
  localparam int PIPE_N   = FRONT_N + SQ_N + 3 + DIV_LAT + 1;

  typedef logic [Q_W-1:0] q30_t;

  localparam q30_t Q_ONE = {1'b1, {WF{1'b0}}};
  localparam logic [IN_W-1:0] IN_ONE = IN_W'(1 << IN_FRAC_BITS);
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [OUT_W-1:0] SAT32 = '1;

  // Front end output word.
  typedef struct packed {
    q30_t nl;
    q30_t nv;
    q30_t a2;
    q30_t dn2;
    logic [2:0][Q_W-1:0] f;
    q30_t qv;
    q30_t ql;
    logic clip;
  } fr_t;

  // Side data that rides next to the square roots.
  typedef struct packed {
    q30_t nl;
    q30_t nv;
    q30_t a2;
    q30_t dn2;
    logic [2:0][Q_W-1:0] f;
    logic clip;
  } side_t;

  // Zero denominator and clip flags that ride next to the dividers.
  typedef struct packed {
    logic dz;
    logic clip;
  } flag_t;

  // Q.30 product, floored back to Q.30; both operands are at most one.
  function automatic q30_t mulw(input q30_t a, input q30_t b);
    logic [2*Q_W-1:0] p;
    p = a * b;
    return p[WF +: Q_W];
  endfunction

  // Clamp an input to one and move it to Q.30.
  function automatic q30_t to_work(input logic [IN_W-1:0] v);
    logic [IN_W-1:0] c;
    c = (v > IN_ONE) ? IN_ONE : v;
    return q30_t'(c) << (WF - IN_FRAC_BITS);
  endfunction

endpackage

// ----- sv/ggxb_front.sv -----
// Front end of the GGX specular pipeline: clamping, alpha2, Fresnel, distribution.
// Four register stages; depends on ggxb_pkg.
module ggxb_front (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ggxb_pkg::IN_W-1:0] n_dot_l,
  input  logic [ggxb_pkg::IN_W-1:0] n_dot_v,
  input  logic [ggxb_pkg::IN_W-1:0] n_dot_h,
  input  logic [ggxb_pkg::IN_W-1:0] l_dot_h,
  input  logic [ggxb_pkg::IN_W-1:0] rough,
  input  logic [ggxb_pkg::IN_W-1:0] f0_red,
  input  logic [ggxb_pkg::IN_W-1:0] f0_green,
  input  logic [ggxb_pkg::IN_W-1:0] f0_blue,
  output ggxb_pkg::fr_t             fr_o
);
  import ggxb_pkg::*;

  q30_t nl_nxt, nv_nxt, nh_nxt, lh_nxt, r_nxt, t_nxt;
  logic [2:0][Q_W-1:0] f0_nxt;
  logic clip_nxt;

  q30_t a_nl_r, a_nv_r, a_t_r, a_a2_r, a_t2_r, a_nh2_r, a_nv2_r, a_nl2_r;
  logic [2:0][Q_W-1:0] a_f0_r;
  logic a_clip_r;

  q30_t oma;
  q30_t b_nl_r, b_nv_r, b_t_r, b_a2_r, b_t4_r, b_xh_r, b_xv_r, b_xl_r;
  logic [2:0][Q_W-1:0] b_f0_r;
  logic b_clip_r;

  q30_t c_nl_r, c_nv_r, c_a2_r, c_t5_r, c_dn_r, c_qv_r, c_ql_r;
  logic [2:0][Q_W-1:0] c_f0_r;
  logic c_clip_r;

  fr_t fr_nxt, fr_r;

  // Clamp the inputs and flag any that sat above one.
  always_comb begin
    clip_nxt = (n_dot_l > IN_ONE) | (n_dot_v > IN_ONE) | (n_dot_h > IN_ONE) |
               (l_dot_h > IN_ONE) | (rough > IN_ONE) | (f0_red > IN_ONE) |
               (f0_green > IN_ONE) | (f0_blue > IN_ONE);
    nl_nxt    = to_work(n_dot_l);
    nv_nxt    = to_work(n_dot_v);
    nh_nxt    = to_work(n_dot_h);
    lh_nxt    = to_work(l_dot_h);
    r_nxt     = to_work(rough);
    f0_nxt[0] = to_work(f0_red);
    f0_nxt[1] = to_work(f0_green);
    f0_nxt[2] = to_work(f0_blue);
    t_nxt     = Q_ONE - lh_nxt;
  end

  // Stage A: the squares.
  always_ff @(posedge clk) begin
    if (en) begin
      a_nl_r   <= nl_nxt;
      a_nv_r   <= nv_nxt;
      a_t_r    <= t_nxt;
      a_a2_r   <= mulw(r_nxt, r_nxt);
      a_t2_r   <= mulw(t_nxt, t_nxt);
      a_nh2_r  <= mulw(nh_nxt, nh_nxt);
      a_nv2_r  <= mulw(nv_nxt, nv_nxt);
      a_nl2_r  <= mulw(nl_nxt, nl_nxt);
      a_f0_r   <= f0_nxt;
      a_clip_r <= clip_nxt;
    end
  end

  assign oma = Q_ONE - a_a2_r;

  // Stage B: fourth power of t and the cosines scaled by one minus alpha2.
  always_ff @(posedge clk) begin
    if (en) begin
      b_nl_r   <= a_nl_r;
      b_nv_r   <= a_nv_r;
      b_t_r    <= a_t_r;
      b_a2_r   <= a_a2_r;
      b_t4_r   <= mulw(a_t2_r, a_t2_r);
      b_xh_r   <= mulw(a_nh2_r, oma);
      b_xv_r   <= mulw(a_nv2_r, oma);
      b_xl_r   <= mulw(a_nl2_r, oma);
      b_f0_r   <= a_f0_r;
      b_clip_r <= a_clip_r;
    end
  end

  // Stage C: fifth power, distribution base and the two radicands.
  always_ff @(posedge clk) begin
    if (en) begin
      c_nl_r   <= b_nl_r;
      c_nv_r   <= b_nv_r;
      c_a2_r   <= b_a2_r;
      c_t5_r   <= mulw(b_t4_r, b_t_r);
      c_dn_r   <= Q_ONE - b_xh_r;
      c_qv_r   <= b_xv_r + b_a2_r;
      c_ql_r   <= b_xl_r + b_a2_r;
      c_f0_r   <= b_f0_r;
      c_clip_r <= b_clip_r;
    end
  end

  // Stage D: squared distribution base and the Schlick term per channel.
  always_comb begin
    fr_nxt.nl   = c_nl_r;
    fr_nxt.nv   = c_nv_r;
    fr_nxt.a2   = c_a2_r;
    fr_nxt.dn2  = mulw(c_dn_r, c_dn_r);
    for (int ch = 0; ch < 3; ch++) begin
      fr_nxt.f[ch] = c_f0_r[ch] + mulw(Q_ONE - c_f0_r[ch], c_t5_r);
    end
    fr_nxt.qv   = c_qv_r;
    fr_nxt.ql   = c_ql_r;
    fr_nxt.clip = c_clip_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r <= fr_nxt;
    end
  end

  assign fr_o = fr_r;

endmodule

// ----- sv/ggxb_sqrt.sv -----
// Pipelined floor square root of a Q.30 value, one root bit per stage.
// One word per cycle while en is high; depends on ggxb_pkg.
module ggxb_sqrt (
  input  logic           clk,
  input  logic           en,
  input  ggxb_pkg::q30_t rad_i,
  output ggxb_pkg::q30_t root_o
);
  import ggxb_pkg::*;

  logic [SQ_REM_W-1:0] rem_r [SQ_N];
  q30_t                root_r [SQ_N];
  logic [SQ_X_W-1:0]   x_r [SQ_N];

  logic [SQ_REM_W-1:0] rem_in [SQ_N];
  q30_t                root_in [SQ_N];
  logic [SQ_X_W-1:0]   x_in [SQ_N];

  logic [SQ_REM_W-1:0] rem_s [SQ_N];
  logic [SQ_REM_W-1:0] trial [SQ_N];
  logic [SQ_REM_W-1:0] rem_nxt [SQ_N];
  q30_t                root_nxt [SQ_N];
  logic [SQ_X_W-1:0]   x_nxt [SQ_N];

  // Stage inputs: the radicand is the value shifted up by 30 bits.
  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    x_in[0]    = {1'b0, rad_i, {WF{1'b0}}};
    for (int k = 1; k < SQ_N; k++) begin
      rem_in[k]  = rem_r[k-1];
      root_in[k] = root_r[k-1];
      x_in[k]    = x_r[k-1];
    end
  end

  // One digit per stage: bring down two bits and try the next root bit.
  always_comb begin
    for (int k = 0; k < SQ_N; k++) begin
      rem_s[k] = {rem_in[k][SQ_REM_W-3:0], x_in[k][SQ_X_W-1 -: 2]};
      trial[k] = SQ_REM_W'({root_in[k], 2'b01});
      x_nxt[k] = x_in[k] << 2;
      if (rem_s[k] >= trial[k]) begin
        rem_nxt[k]  = rem_s[k] - trial[k];
        root_nxt[k] = {root_in[k][Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_s[k];
        root_nxt[k] = {root_in[k][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        x_r[k]    <= x_nxt[k];
      end
    end
  end

  assign root_o = root_r[SQ_N-1];

endmodule

// ----- sv/ggxb_div.sv -----
// Pipelined saturating divider: a range check stage, then one quotient bit per stage.
// One word per cycle while en is high; depends on ggxb_pkg.
module ggxb_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ggxb_pkg::NUM_W-1:0] num_i,
  input  logic [ggxb_pkg::DEN_W-1:0] den_i,
  output logic [ggxb_pkg::OUT_W-1:0] quo_o,
  output logic                       sat_o
);
  import ggxb_pkg::*;

  logic                sat0_r;
  logic [DEN_W-1:0]    rem0_r, den0_r;
  logic [OUT_W-1:0]    low0_r;

  logic                sat_r [DIV_N];
  logic [DEN_W-1:0]    rem_r [DIV_N];
  logic [DEN_W-1:0]    den_r [DIV_N];
  logic [OUT_W-1:0]    low_r [DIV_N];
  logic [OUT_W-1:0]    quo_r [DIV_N];

  logic [DEN_W-1:0]    rem_in [DIV_N];
  logic [DEN_W-1:0]    den_in [DIV_N];
  logic [OUT_W-1:0]    low_in [DIV_N];
  logic [OUT_W-1:0]    quo_in [DIV_N];
  logic                sat_in [DIV_N];
  logic [DEN_W:0]      rem_s [DIV_N];
  logic [DEN_W-1:0]    rem_nxt [DIV_N];
  logic [OUT_W-1:0]    quo_nxt [DIV_N];

  // Range check: the quotient overflows 32 bits when num >= den * 2^32.
  always_ff @(posedge clk) begin
    if (en) begin
      sat0_r <= {{(DEN_W + OUT_W - NUM_W){1'b0}}, num_i} >= {den_i, {OUT_W{1'b0}}};
      rem0_r <= {{(DEN_W - (NUM_W - OUT_W)){1'b0}}, num_i[NUM_W-1:OUT_W]};
      low0_r <= num_i[OUT_W-1:0];
      den0_r <= den_i;
    end
  end

  // Stage inputs.
  always_comb begin
    rem_in[0] = rem0_r;
    den_in[0] = den0_r;
    low_in[0] = low0_r;
    quo_in[0] = '0;
    sat_in[0] = sat0_r;
    for (int k = 1; k < DIV_N; k++) begin
      rem_in[k] = rem_r[k-1];
      den_in[k] = den_r[k-1];
      low_in[k] = low_r[k-1];
      quo_in[k] = quo_r[k-1];
      sat_in[k] = sat_r[k-1];
    end
  end

  // Restoring step: bring down one dividend bit, subtract where it fits.
  always_comb begin
    for (int k = 0; k < DIV_N; k++) begin
      rem_s[k] = {rem_in[k], low_in[k][OUT_W-1]};
      if (rem_s[k] >= {1'b0, den_in[k]}) begin
        rem_nxt[k] = DEN_W'(rem_s[k] - {1'b0, den_in[k]});
        quo_nxt[k] = {quo_in[k][OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_s[k][DEN_W-1:0];
        quo_nxt[k] = {quo_in[k][OUT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_N; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_in[k];
        low_r[k] <= low_in[k] << 1;
        sat_r[k] <= sat_in[k];
      end
    end
  end

  assign quo_o = quo_r[DIV_N-1];
  assign sat_o = sat_r[DIV_N-1];

endmodule

// ----- sv/ggx_specular_brdf.sv -----
// GGX specular term: one result word for each accepted input word. Throughput one
// word per cycle while the output is not stalled; the two 31-stage square roots and
// the three 33-stage dividers are fully pipelined, so every stage holds its own word.
// A stall at the output freezes every stage at once; the valid bits clear on reset.
// Reset is synchronous and active low and touches only the valid bits.
module ggx_specular_brdf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ggxb_pkg::IN_W-1:0]   in_n_dot_l,
  input  logic [ggxb_pkg::IN_W-1:0]   in_n_dot_v,
  input  logic [ggxb_pkg::IN_W-1:0]   in_n_dot_h,
  input  logic [ggxb_pkg::IN_W-1:0]   in_l_dot_h,
  input  logic [ggxb_pkg::IN_W-1:0]   in_rough,
  input  logic [ggxb_pkg::IN_W-1:0]   in_f0_red,
  input  logic [ggxb_pkg::IN_W-1:0]   in_f0_green,
  input  logic [ggxb_pkg::IN_W-1:0]   in_f0_blue,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ggxb_pkg::OUT_W-1:0]  out_spec_red,
  output logic [ggxb_pkg::OUT_W-1:0]  out_spec_green,
  output logic [ggxb_pkg::OUT_W-1:0]  out_spec_blue,
  output logic                        out_clipped
);
  import ggxb_pkg::*;
  `include "ggx_specular_brdf_assert.svh"

  logic              en;
  logic [PIPE_N-1:0] vld_r;
  fr_t               fr;
  q30_t              root_v, root_l;
  side_t             side_nxt;
  side_t             side_r [SQ_N];

  logic [LAM_W-1:0]  lam_nxt, lam_r;
  side_t             e_side_r, f_side_r;
  logic [Q_W+LAM_W-1:0] x_prod;
  logic [X_W-1:0]    x_r;
  logic [X_W+31:0]   den_prod;
  logic [DEN_W-1:0]  den_nxt, den_r;
  logic [2*Q_W-1:0]  num_prod [3];
  logic [NUM_W-1:0]  num_r [3];
  flag_t             g_flag_r;
  flag_t             flag_r [DIV_LAT];

  logic [OUT_W-1:0]  quo [3];
  logic              sat [3];
  logic [OUT_W-1:0]  spec_nxt [3];
  logic              clip_nxt;
  logic [OUT_W-1:0]  spec_r [3];
  logic              clip_r;

  // The whole pipeline moves unless a finished word waits at the output.
  assign en       = !(vld_r[PIPE_N-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_N-2:0], in_valid};
    end
  end

  ggxb_front u_front (
    .clk      (clk),
    .en       (en),
    .n_dot_l  (in_n_dot_l),
    .n_dot_v  (in_n_dot_v),
    .n_dot_h  (in_n_dot_h),
    .l_dot_h  (in_l_dot_h),
    .rough    (in_rough),
    .f0_red   (in_f0_red),
    .f0_green (in_f0_green),
    .f0_blue  (in_f0_blue),
    .fr_o     (fr)
  );

  // Square roots for the view and light visibility terms.
  ggxb_sqrt u_sqrt_v (.clk(clk), .en(en), .rad_i(fr.qv), .root_o(root_v));
  ggxb_sqrt u_sqrt_l (.clk(clk), .en(en), .rad_i(fr.ql), .root_o(root_l));

  // Side data delay line, matched to the square root latency.
  always_comb begin
    side_nxt.nl   = fr.nl;
    side_nxt.nv   = fr.nv;
    side_nxt.a2   = fr.a2;
    side_nxt.dn2  = fr.dn2;
    side_nxt.f    = fr.f;
    side_nxt.clip = fr.clip;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < SQ_N; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Stage E: sum of the two lambda terms.
  assign lam_nxt = {1'b0, mulw(side_r[SQ_N-1].nl, root_v)} +
                   {1'b0, mulw(side_r[SQ_N-1].nv, root_l)};

  always_ff @(posedge clk) begin
    if (en) begin
      lam_r    <= lam_nxt;
      e_side_r <= side_r[SQ_N-1];
    end
  end

  // Stage F: squared distribution base times lambda.
  assign x_prod = e_side_r.dn2 * lam_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r      <= x_prod[WF +: X_W];
      f_side_r <= e_side_r;
    end
  end

  // Stage G: denominator with pi, and the numerators already shifted down.
  always_comb begin
    den_prod = PI_Q30 * x_r;
    den_nxt  = den_prod[WF +: DEN_W];
    for (int ch = 0; ch < 3; ch++) begin
      num_prod[ch] = f_side_r.f[ch] * f_side_r.a2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r         <= den_nxt;
      g_flag_r.dz   <= (den_nxt == '0);
      g_flag_r.clip <= f_side_r.clip;
      for (int ch = 0; ch < 3; ch++) begin
        num_r[ch] <= num_prod[ch][NUM_SH +: NUM_W];
      end
    end
  end

  // One divider per color channel.
  ggxb_div u_div_r (.clk(clk), .en(en), .num_i(num_r[0]), .den_i(den_r),
                    .quo_o(quo[0]), .sat_o(sat[0]));
  ggxb_div u_div_g (.clk(clk), .en(en), .num_i(num_r[1]), .den_i(den_r),
                    .quo_o(quo[1]), .sat_o(sat[1]));
  ggxb_div u_div_b (.clk(clk), .en(en), .num_i(num_r[2]), .den_i(den_r),
                    .quo_o(quo[2]), .sat_o(sat[2]));

  // Flags ride next to the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      flag_r[0] <= g_flag_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        flag_r[k] <= flag_r[k-1];
      end
    end
  end

  // Saturation and the zero denominator case.
  always_comb begin
    clip_nxt = flag_r[DIV_LAT-1].clip | flag_r[DIV_LAT-1].dz;
    for (int ch = 0; ch < 3; ch++) begin
      if (flag_r[DIV_LAT-1].dz || sat[ch]) begin
        spec_nxt[ch] = SAT32;
      end else begin
        spec_nxt[ch] = quo[ch];
      end
      clip_nxt = clip_nxt | sat[ch];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        spec_r[ch] <= spec_nxt[ch];
      end
      clip_r <= clip_nxt;
    end
  end

  assign out_valid      = vld_r[PIPE_N-1];
  assign out_spec_red   = spec_r[0];
  assign out_spec_green = spec_r[1];
  assign out_spec_blue  = spec_r[2];
  assign out_clipped    = clip_r;

  // A stall freezes the valid map of every stage.
  `GGXB_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld_r), "valid map moved during a stall")
  // An accepted word enters the first stage.
  `GGXB_ASSERT_NEXT(a_accept_enters, in_valid && en, vld_r[0], "accepted word was lost")
  // A zero denominator leaves as a clipped, saturated word.
  `GGXB_ASSERT_NEXT(a_zero_den_sat, en && vld_r[PIPE_N-2] && flag_r[DIV_LAT-1].dz,
                    out_clipped && out_spec_red == SAT32 && out_spec_blue == SAT32,
                    "zero denominator did not saturate")

endmodule
